// ===== design/buddy_pkg.sv =====
// shared types, codes and defaults of the buddy allocator
`timescale 1ns / 1ps
`default_nettype none

package buddy_pkg;

    localparam int MAX_ORDER_DEF = 10;

    localparam logic [31:0] REGION_SIZE_RST    = 32'd1024;
    localparam logic [31:0] SMALLEST_BLOCK_RST = 32'd16;
    localparam logic [31:0] GRANT_RST          = 32'd1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_SIZE    = 1'b0,
        CFG_SMALLEST_BLOCK = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NOT_INIT   = 3'd1,
        STAT_NO_BLOCK   = 3'd2,
        STAT_UNKNOWN_ID = 3'd3,
        STAT_BAD_SIZES  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] request_size;
        logic [31:0] release_id;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] grant_id;
        logic [30:0] block_offset;
        logic [31:0] block_bytes;
        logic [31:0] bytes_in_use;
    } rsp_word_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_POW,
        S_ICHK,
        S_CLR_I,
        S_IFIN,
        S_CLR_R,
        S_RFIN,
        S_ACHK,
        S_ASIZE,
        S_ARD,
        S_AWORD,
        S_SPLIT,
        S_SRD,
        S_SWR,
        S_FRD,
        S_FCHK,
        S_MRD,
        S_MWR,
        S_RESP
    } state_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LATCH,
        DP_POW_STEP,
        DP_INIT_COMMIT,
        DP_STATUS,
        DP_CLR_STEP,
        DP_INIT_FIN,
        DP_RST_FIN,
        DP_SIZE_INIT,
        DP_SIZE_STEP,
        DP_SCAN_START,
        DP_SCAN_RD,
        DP_SCAN_NEXT,
        DP_TAKE,
        DP_SPLIT_DN,
        DP_SPLIT_RD,
        DP_SPLIT_WR,
        DP_ALLOC_FIN,
        DP_F_RD,
        DP_F_NEXT,
        DP_F_HIT,
        DP_MRG_RD,
        DP_MRG_WR,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ready_flag;
        logic pow_done;
        logic init_ok;
        logic too_big;
        logic size_done;
        logic word_hit;
        logic scan_end;
        logic split_more;
        logic slot_hit;
        logic slot_end;
        logic merge_go;
        logic clr_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/buddy_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module buddy_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/buddy_ctrl.sv =====
// sequencer of the buddy allocator: one operation at a time
`timescale 1ns / 1ps
`default_nettype none

module buddy_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic [1:0]          operation,
    input  wire buddy_pkg::dp_stat_t stat,
    output logic                     req_ready,
    output buddy_pkg::ctrl_cmd_t     cmd
);

    buddy_pkg::state_t state_reg;
    buddy_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= buddy_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            buddy_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (operation)
                        buddy_pkg::OP_ALLOC:
                            state_next = stat.ready_flag ? buddy_pkg::S_ACHK
                                                         : buddy_pkg::S_RESP;
                        buddy_pkg::OP_FREE:
                            state_next = stat.ready_flag ? buddy_pkg::S_FRD
                                                         : buddy_pkg::S_RESP;
                        buddy_pkg::OP_INIT:
                            state_next = buddy_pkg::S_POW;
                        default:
                            state_next = buddy_pkg::S_CLR_R;
                    endcase
                end
            end
            buddy_pkg::S_POW:
                if (stat.pow_done) state_next = buddy_pkg::S_ICHK;
            buddy_pkg::S_ICHK:
                state_next = stat.init_ok ? buddy_pkg::S_CLR_I : buddy_pkg::S_RESP;
            buddy_pkg::S_CLR_I:
                if (stat.clr_last) state_next = buddy_pkg::S_IFIN;
            buddy_pkg::S_IFIN:
                state_next = buddy_pkg::S_RESP;
            buddy_pkg::S_CLR_R:
                if (stat.clr_last) state_next = buddy_pkg::S_RFIN;
            buddy_pkg::S_RFIN:
                state_next = buddy_pkg::S_RESP;
            buddy_pkg::S_ACHK:
                state_next = stat.too_big ? buddy_pkg::S_RESP : buddy_pkg::S_ASIZE;
            buddy_pkg::S_ASIZE:
                if (stat.size_done) state_next = buddy_pkg::S_ARD;
            buddy_pkg::S_ARD:
                state_next = buddy_pkg::S_AWORD;
            buddy_pkg::S_AWORD:
            begin
                if (stat.word_hit)
                    state_next = buddy_pkg::S_SPLIT;
                else if (stat.scan_end)
                    state_next = buddy_pkg::S_RESP;
                else
                    state_next = buddy_pkg::S_ARD;
            end
            buddy_pkg::S_SPLIT:
                state_next = stat.split_more ? buddy_pkg::S_SRD : buddy_pkg::S_RESP;
            buddy_pkg::S_SRD:
                state_next = buddy_pkg::S_SWR;
            buddy_pkg::S_SWR:
                state_next = buddy_pkg::S_SPLIT;
            buddy_pkg::S_FRD:
                state_next = buddy_pkg::S_FCHK;
            buddy_pkg::S_FCHK:
            begin
                if (stat.slot_hit)
                    state_next = buddy_pkg::S_MRD;
                else if (stat.slot_end)
                    state_next = buddy_pkg::S_RESP;
                else
                    state_next = buddy_pkg::S_FRD;
            end
            buddy_pkg::S_MRD:
                state_next = buddy_pkg::S_MWR;
            buddy_pkg::S_MWR:
                state_next = stat.merge_go ? buddy_pkg::S_MRD : buddy_pkg::S_RESP;
            buddy_pkg::S_RESP:
                if (stat.out_free) state_next = buddy_pkg::S_IDLE;
            default:
                state_next = buddy_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = buddy_pkg::DP_NONE;
        cmd.code  = buddy_pkg::STAT_OK;
        req_ready = 1'b0;
        case (state_reg)
            buddy_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = buddy_pkg::DP_LATCH;
                    if ((operation == buddy_pkg::OP_ALLOC || operation == buddy_pkg::OP_FREE)
                        && !stat.ready_flag)
                    begin
                        cmd.code = buddy_pkg::STAT_NOT_INIT;
                    end
                end
            end
            buddy_pkg::S_POW:
                cmd.op = buddy_pkg::DP_POW_STEP;
            buddy_pkg::S_ICHK:
            begin
                if (stat.init_ok)
                begin
                    cmd.op = buddy_pkg::DP_INIT_COMMIT;
                end
                else
                begin
                    cmd.op   = buddy_pkg::DP_STATUS;
                    cmd.code = buddy_pkg::STAT_BAD_SIZES;
                end
            end
            buddy_pkg::S_CLR_I,
            buddy_pkg::S_CLR_R:
                cmd.op = buddy_pkg::DP_CLR_STEP;
            buddy_pkg::S_IFIN:
                cmd.op = buddy_pkg::DP_INIT_FIN;
            buddy_pkg::S_RFIN:
                cmd.op = buddy_pkg::DP_RST_FIN;
            buddy_pkg::S_ACHK:
            begin
                if (stat.too_big)
                begin
                    cmd.op   = buddy_pkg::DP_STATUS;
                    cmd.code = buddy_pkg::STAT_NO_BLOCK;
                end
                else
                begin
                    cmd.op = buddy_pkg::DP_SIZE_INIT;
                end
            end
            buddy_pkg::S_ASIZE:
                cmd.op = stat.size_done ? buddy_pkg::DP_SCAN_START : buddy_pkg::DP_SIZE_STEP;
            buddy_pkg::S_ARD:
                cmd.op = buddy_pkg::DP_SCAN_RD;
            buddy_pkg::S_AWORD:
            begin
                if (stat.word_hit)
                begin
                    cmd.op = buddy_pkg::DP_TAKE;
                end
                else if (stat.scan_end)
                begin
                    cmd.op   = buddy_pkg::DP_STATUS;
                    cmd.code = buddy_pkg::STAT_NO_BLOCK;
                end
                else
                begin
                    cmd.op = buddy_pkg::DP_SCAN_NEXT;
                end
            end
            buddy_pkg::S_SPLIT:
                cmd.op = stat.split_more ? buddy_pkg::DP_SPLIT_DN : buddy_pkg::DP_ALLOC_FIN;
            buddy_pkg::S_SRD:
                cmd.op = buddy_pkg::DP_SPLIT_RD;
            buddy_pkg::S_SWR:
                cmd.op = buddy_pkg::DP_SPLIT_WR;
            buddy_pkg::S_FRD:
                cmd.op = buddy_pkg::DP_F_RD;
            buddy_pkg::S_FCHK:
            begin
                if (stat.slot_hit)
                begin
                    cmd.op = buddy_pkg::DP_F_HIT;
                end
                else if (stat.slot_end)
                begin
                    cmd.op   = buddy_pkg::DP_STATUS;
                    cmd.code = buddy_pkg::STAT_UNKNOWN_ID;
                end
                else
                begin
                    cmd.op = buddy_pkg::DP_F_NEXT;
                end
            end
            buddy_pkg::S_MRD:
                cmd.op = buddy_pkg::DP_MRG_RD;
            buddy_pkg::S_MWR:
                cmd.op = buddy_pkg::DP_MRG_WR;
            buddy_pkg::S_RESP:
                if (stat.out_free) cmd.op = buddy_pkg::DP_EMIT;
            default:
                cmd.op = buddy_pkg::DP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/buddy_dp.sv =====
// datapath of the buddy allocator: registers, free bitmap and slot records
`timescale 1ns / 1ps
`default_nettype none

module buddy_dp #(
    parameter int MAX_ORDER = buddy_pkg::MAX_ORDER_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [buddy_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [buddy_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire buddy_pkg::req_word_t                req,
    input  wire buddy_pkg::ctrl_cmd_t                cmd,
    input  wire logic                                rsp_ready,
    output buddy_pkg::dp_stat_t                      stat,
    output logic                                     rsp_valid,
    output buddy_pkg::rsp_word_t                     rsp
);

    localparam int LVL_W  = $clog2(MAX_ORDER + 1);
    localparam int POS_W  = MAX_ORDER;
    localparam int BIT_W  = (MAX_ORDER < 5) ? MAX_ORDER : 5;
    localparam int FW     = 1 << BIT_W;
    localparam int WIDX_W = (MAX_ORDER > BIT_W) ? MAX_ORDER - BIT_W : 1;
    localparam int BM_AW  = LVL_W + WIDX_W;
    localparam int BM_DEPTH = 1 << BM_AW;
    localparam int SLOTS  = 1 << POS_W;
    localparam int REC_W  = 1 + 32 + LVL_W;
    localparam int CLR_W  = (BM_AW > POS_W) ? BM_AW : POS_W;

    function automatic logic [BIT_W-1:0] low_one(input logic [FW-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = FW - 1; i >= 0; i--)
        begin
            if (w[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    // configuration
    logic [31:0] region_cfg_reg;
    logic [31:0] small_cfg_reg;

    // allocator state
    logic             ready_reg;
    logic [4:0]       mp_reg;
    logic [LVL_W-1:0] top_reg;
    logic [31:0]      min_bytes_reg;
    logic [31:0]      region_bytes_reg;
    logic [31:0]      in_use_reg;
    logic [31:0]      next_grant_reg;

    // per operation scratch
    logic [31:0]       size_reg;
    logic [31:0]       id_reg;
    logic [32:0]       rr_reg;
    logic [32:0]       mr_reg;
    logic [5:0]        rp_reg;
    logic [5:0]        mpw_reg;
    logic [31:0]       blk_reg;
    logic [LVL_W-1:0]  need_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic [POS_W-1:0]  slot_reg;
    logic [CLR_W-1:0]  clr_reg;
    buddy_pkg::rsp_word_t res_reg;
    buddy_pkg::rsp_word_t rsp_reg;
    logic                 rsp_valid_reg;

    // memory ports
    logic              bm_we;
    logic [BM_AW-1:0]  bm_waddr;
    logic [FW-1:0]     bm_wdata;
    logic [BM_AW-1:0]  bm_raddr;
    logic [FW-1:0]     bm_rdata;
    logic              rec_we;
    logic [POS_W-1:0]  rec_waddr;
    logic [REC_W-1:0]  rec_wdata;
    logic [REC_W-1:0]  rec_rdata;

    // derived values
    logic [BIT_W-1:0]  pos_bit;
    logic [WIDX_W-1:0] pos_widx;
    logic [LVL_W-1:0]  span;
    logic [WIDX_W:0]   one_sh;
    logic [WIDX_W-1:0] last_widx;
    logic [BIT_W-1:0]  hit_bit;
    logic [FW-1:0]     hit_mask;
    logic [FW-1:0]     pos_mask;
    logic [FW-1:0]     buddy_mask;
    logic [FW-1:0]     mw;
    logic              merge_go;
    logic              rec_busy;
    logic [31:0]       rec_id;
    logic [LVL_W-1:0]  rec_lvl;
    logic [POS_W:0]    slot_span;
    logic [POS_W-1:0]  slot_last;
    logic [POS_W-1:0]  alloc_slot;
    logic [31:0]       rel_bytes;

    assign pos_bit    = pos_reg[BIT_W-1:0];
    assign pos_widx   = WIDX_W'(pos_reg >> BIT_W);
    assign span       = top_reg - lvl_reg;
    assign one_sh     = (WIDX_W + 1)'(1) << (span - LVL_W'(BIT_W));
    assign last_widx  = (span > LVL_W'(BIT_W)) ? WIDX_W'(one_sh - (WIDX_W + 1)'(1)) : '0;
    assign hit_bit    = low_one(bm_rdata);
    assign hit_mask   = FW'(1) << hit_bit;
    assign pos_mask   = FW'(1) << pos_bit;
    assign buddy_mask = FW'(1) << (pos_bit ^ BIT_W'(1));
    assign mw         = bm_rdata | pos_mask;
    assign merge_go   = (lvl_reg < top_reg) && ((mw & buddy_mask) != '0);
    assign rec_busy   = rec_rdata[REC_W-1];
    assign rec_id     = rec_rdata[LVL_W +: 32];
    assign rec_lvl    = rec_rdata[LVL_W-1:0];
    assign slot_span  = (POS_W + 1)'(1) << top_reg;
    assign slot_last  = POS_W'(slot_span - (POS_W + 1)'(1));
    assign alloc_slot = POS_W'(pos_reg << need_reg);
    assign rel_bytes  = min_bytes_reg << rec_lvl;

    always_comb
    begin
        stat.ready_flag = ready_reg;
        stat.pow_done   = !(rr_reg < {1'b0, region_cfg_reg}) && !(mr_reg < {1'b0, small_cfg_reg});
        stat.init_ok    = (region_cfg_reg != '0) && (small_cfg_reg != '0)
                          && (small_cfg_reg <= region_cfg_reg) && (rp_reg <= 6'd31)
                          && (mpw_reg <= rp_reg) && ((rp_reg - mpw_reg) <= 6'(MAX_ORDER));
        stat.too_big    = size_reg > region_bytes_reg;
        stat.size_done  = !((need_reg < top_reg) && (blk_reg < size_reg));
        stat.word_hit   = bm_rdata != '0;
        stat.scan_end   = (widx_reg == last_widx) && (lvl_reg == top_reg);
        stat.split_more = lvl_reg > need_reg;
        stat.slot_hit   = rec_busy && (rec_id == id_reg);
        stat.slot_end   = slot_reg == slot_last;
        stat.merge_go   = merge_go;
        stat.clr_last   = &clr_reg;
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

    // memory port selection
    always_comb
    begin
        bm_we     = 1'b0;
        bm_waddr  = {lvl_reg, pos_widx};
        bm_wdata  = mw;
        bm_raddr  = (cmd.op == buddy_pkg::DP_SCAN_RD) ? {lvl_reg, widx_reg}
                                                      : {lvl_reg, pos_widx};
        rec_we    = 1'b0;
        rec_waddr = slot_reg;
        rec_wdata = '0;
        case (cmd.op)
            buddy_pkg::DP_CLR_STEP:
            begin
                bm_we     = 1'b1;
                bm_waddr  = BM_AW'(clr_reg);
                bm_wdata  = '0;
                rec_we    = 1'b1;
                rec_waddr = POS_W'(clr_reg);
            end
            buddy_pkg::DP_INIT_FIN:
            begin
                // whole region free as one block at the top level
                bm_we    = 1'b1;
                bm_waddr = {top_reg, {WIDX_W{1'b0}}};
                bm_wdata = FW'(1);
            end
            buddy_pkg::DP_TAKE:
            begin
                bm_we    = 1'b1;
                bm_waddr = {lvl_reg, widx_reg};
                bm_wdata = bm_rdata & ~hit_mask;
            end
            buddy_pkg::DP_SPLIT_WR:
            begin
                // upper half of the split block becomes free
                bm_we    = 1'b1;
                bm_wdata = bm_rdata | buddy_mask;
            end
            buddy_pkg::DP_MRG_WR:
            begin
                bm_we    = 1'b1;
                bm_wdata = merge_go ? (mw & ~pos_mask & ~buddy_mask) : mw;
            end
            buddy_pkg::DP_ALLOC_FIN:
            begin
                rec_we    = 1'b1;
                rec_waddr = alloc_slot;
                rec_wdata = {1'b1, next_grant_reg, need_reg};
            end
            buddy_pkg::DP_F_HIT:
                rec_we = 1'b1;
            default:
                bm_we = 1'b0;
        endcase
    end

    buddy_ram #(
        .WIDTH (FW),
        .DEPTH (BM_DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    buddy_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_records (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (slot_reg),
        .rdata (rec_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_cfg_reg   <= buddy_pkg::REGION_SIZE_RST;
            small_cfg_reg    <= buddy_pkg::SMALLEST_BLOCK_RST;
            ready_reg        <= 1'b0;
            mp_reg           <= '0;
            top_reg          <= '0;
            in_use_reg       <= '0;
            next_grant_reg   <= buddy_pkg::GRANT_RST;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    buddy_pkg::CFG_REGION_SIZE:    region_cfg_reg <= cfg_data;
                    buddy_pkg::CFG_SMALLEST_BLOCK: small_cfg_reg  <= cfg_data;
                    default:                       region_cfg_reg <= region_cfg_reg;
                endcase
            end
            case (cmd.op)
                buddy_pkg::DP_INIT_COMMIT:
                begin
                    mp_reg    <= mpw_reg[4:0];
                    top_reg   <= LVL_W'(rp_reg - mpw_reg);
                    ready_reg <= 1'b0;
                end
                buddy_pkg::DP_INIT_FIN:
                begin
                    ready_reg  <= 1'b1;
                    in_use_reg <= '0;
                end
                buddy_pkg::DP_RST_FIN:
                begin
                    ready_reg  <= 1'b0;
                    in_use_reg <= '0;
                end
                buddy_pkg::DP_ALLOC_FIN:
                begin
                    in_use_reg     <= in_use_reg + blk_reg;
                    next_grant_reg <= next_grant_reg + 32'd1;
                end
                buddy_pkg::DP_F_HIT:
                    in_use_reg <= (in_use_reg >= rel_bytes) ? in_use_reg - rel_bytes : '0;
                default:
                    ready_reg <= ready_reg;
            endcase
            if (cmd.op == buddy_pkg::DP_EMIT)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // scratch and result payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            buddy_pkg::DP_LATCH:
            begin
                size_reg             <= req.request_size;
                id_reg               <= req.release_id;
                rr_reg               <= 33'd1;
                mr_reg               <= 33'd1;
                rp_reg               <= '0;
                mpw_reg              <= '0;
                clr_reg              <= '0;
                slot_reg             <= '0;
                res_reg.status       <= cmd.code;
                res_reg.grant_id     <= '0;
                res_reg.block_offset <= '0;
                res_reg.block_bytes  <= '0;
                res_reg.bytes_in_use <= '0;
            end
            buddy_pkg::DP_POW_STEP:
            begin
                // round both sizes up to powers of two, one doubling a cycle
                if (rr_reg < {1'b0, region_cfg_reg})
                begin
                    rr_reg <= rr_reg << 1;
                    rp_reg <= rp_reg + 6'd1;
                end
                if (mr_reg < {1'b0, small_cfg_reg})
                begin
                    mr_reg  <= mr_reg << 1;
                    mpw_reg <= mpw_reg + 6'd1;
                end
            end
            buddy_pkg::DP_INIT_COMMIT:
            begin
                min_bytes_reg    <= mr_reg[31:0];
                region_bytes_reg <= rr_reg[31:0];
                lvl_reg          <= '0;
                clr_reg          <= '0;
            end
            buddy_pkg::DP_STATUS:
                res_reg.status <= cmd.code;
            buddy_pkg::DP_CLR_STEP:
                clr_reg <= clr_reg + CLR_W'(1);
            buddy_pkg::DP_SIZE_INIT:
            begin
                blk_reg  <= min_bytes_reg;
                need_reg <= '0;
            end
            buddy_pkg::DP_SIZE_STEP:
            begin
                blk_reg  <= blk_reg << 1;
                need_reg <= need_reg + LVL_W'(1);
            end
            buddy_pkg::DP_SCAN_START:
            begin
                lvl_reg  <= need_reg;
                widx_reg <= '0;
            end
            buddy_pkg::DP_SCAN_NEXT:
            begin
                if (widx_reg == last_widx)
                begin
                    lvl_reg  <= lvl_reg + LVL_W'(1);
                    widx_reg <= '0;
                end
                else
                begin
                    widx_reg <= widx_reg + WIDX_W'(1);
                end
            end
            buddy_pkg::DP_TAKE:
                pos_reg <= POS_W'({widx_reg, hit_bit});
            buddy_pkg::DP_SPLIT_DN:
            begin
                lvl_reg <= lvl_reg - LVL_W'(1);
                pos_reg <= pos_reg << 1;
            end
            buddy_pkg::DP_ALLOC_FIN:
            begin
                res_reg.grant_id     <= next_grant_reg;
                res_reg.block_offset <= 31'(alloc_slot) << mp_reg;
                res_reg.block_bytes  <= blk_reg;
            end
            buddy_pkg::DP_F_NEXT:
                slot_reg <= slot_reg + POS_W'(1);
            buddy_pkg::DP_F_HIT:
            begin
                lvl_reg              <= rec_lvl;
                pos_reg              <= slot_reg >> rec_lvl;
                res_reg.block_offset <= 31'(slot_reg) << mp_reg;
                res_reg.block_bytes  <= rel_bytes;
            end
            buddy_pkg::DP_MRG_WR:
            begin
                if (merge_go)
                begin
                    lvl_reg <= lvl_reg + LVL_W'(1);
                    pos_reg <= pos_reg >> 1;
                end
            end
            buddy_pkg::DP_EMIT:
                rsp_reg <= {res_reg.status, res_reg.grant_id, res_reg.block_offset,
                            res_reg.block_bytes, in_use_reg};
            default:
                blk_reg <= blk_reg;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_init_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == buddy_pkg::DP_INIT_FIN |=> ready_reg)
        else $error("ready flag not set after init");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == buddy_pkg::DP_EMIT |-> (!rsp_valid_reg || rsp_ready))
        else $error("result word overwritten before taken");

    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> top_reg <= LVL_W'(MAX_ORDER))
        else $error("top level beyond max order");

    a_split_above_need: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == buddy_pkg::DP_SPLIT_DN |-> lvl_reg > need_reg)
        else $error("split below requested level");

    a_grant_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == buddy_pkg::DP_ALLOC_FIN |=> next_grant_reg == $past(next_grant_reg) + 32'd1)
        else $error("grant id did not advance");

endmodule

`default_nettype wire

// ===== design/buddy_allocator_core.sv =====
// top level of the buddy allocator
`timescale 1ns / 1ps
`default_nettype none

// Binary buddy allocator: one request word in, one result word out, one operation at a
// time. The free tree is kept as per-level bitmaps in a RAM of 32-bit words (narrower when
// MAX_ORDER < 5), live blocks as one record per minimum-size slot in a second RAM. Alloc
// climbs levels to size the request, scans the bitmap RAM word by word from the needed
// level upward, then splits the found block down level by level. Free searches the record
// RAM slot by slot (up to 2^top_level slots), then merges with free buddies level by level.
// Init rounds both sizes up to powers of two, then runs a clearing pass over both RAMs;
// the reset operation runs the same pass. Results wait in an output register, and the
// next request is taken once the block is back in idle.
module buddy_allocator_core #(
    parameter int MAX_ORDER = buddy_pkg::MAX_ORDER_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [buddy_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [buddy_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire buddy_pkg::req_word_t             req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output buddy_pkg::rsp_word_t                  rsp
);

    buddy_pkg::ctrl_cmd_t cmd;
    buddy_pkg::dp_stat_t  stat;

    buddy_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .operation (req.operation),
        .stat      (stat),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    buddy_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
